>>> sv/sem_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude block.
// No dependencies; every other file but sem_line_buf imports it.
package sem_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned ROW_W    = 11;
  localparam int unsigned WIN_COLS = 2;
  localparam int unsigned MIN_DIM  = 3;
  localparam int unsigned ROW_LIMIT = 2048;
  localparam int unsigned SAT_MAX  = 255;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_addr_e;

  // One column of the 3x3 window, top to bottom.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Column terms: weighted sum (1,2,1) and bottom minus top.
  typedef struct packed {
    logic [PIX_W+1:0]        wsum;
    logic signed [PIX_W:0]   diff;
  } col_terms_t;

  function automatic col_terms_t col_terms(input col_t col);
    col_terms_t t;
    t.wsum = (PIX_W+2)'(col.top) + (PIX_W+2)'({col.mid, 1'b0}) + (PIX_W+2)'(col.bot);
    t.diff = $signed({1'b0, col.bot}) - $signed({1'b0, col.top});
    return t;
  endfunction

endpackage

>>> sv/sem_line_buf.sv
// One line buffer: a single-port-write, registered-read memory.
// Depends on nothing but its parameters.
module sem_line_buf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/sem_col_cell.sv
// Window column cell: holds one 3-pixel column, hands it on each shift.
// Depends on sem_pkg for the column types and the term helper.
module sem_col_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  sem_pkg::col_t       col_i,
  output sem_pkg::col_t       col_o,
  output sem_pkg::col_terms_t terms_o
);
  import sem_pkg::*;

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o   = col_q;
  assign terms_o = col_terms(col_q);

endmodule

>>> sv/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge detector with L1 magnitude.
// Depends on sem_pkg, sem_line_buf and sem_col_cell.

// Gray pixels arrive in raster order, one item per clock when neither side
// stalls. On accept the two line buffers are read into their output
// registers; a later advance of the pipe shifts the window cells and
// registers the magnitude in the output stage.
// One line-buffer read and one write per cycle set the sustained rate of one
// pixel per clock. Pixels in the first two rows or the first two columns of
// a frame give no result; every other pixel gives the magnitude of the
// window centre one row up and one column left, saturated at 255, with last
// set for the final pixel of the frame. frame_start restarts the position at
// row 0, column 0; the line buffers and window keep their data and are
// overwritten as the new frame arrives, so no clearing pass is needed.
// Write image_width and image_height only while the block is idle.
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]     in_pixel_i,
  input  logic                          in_frame_start_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sem_pkg::PIX_W-1:0]     out_magnitude_o,
  output logic                          out_last_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int unsigned EW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_e'(cfg_addr_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
      endcase
    end
  end

  // Clamp the frame size and form the last column / last row indexes.
  logic [EW-1:0]    width_ext, width_cl, width_m1;
  logic [CFG_W-1:0] height_cl, height_m1;

  always_comb begin
    width_ext = EW'(width_q);
    if (width_ext < EW'(MIN_DIM)) begin
      width_cl = EW'(MIN_DIM);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_cl = EW'(MAX_WIDTH);
    end else begin
      width_cl = width_ext;
    end
    width_m1 = width_cl - EW'(1);

    if (height_q < CFG_W'(MIN_DIM)) begin
      height_cl = CFG_W'(MIN_DIM);
    end else if (height_q > CFG_W'(ROW_LIMIT)) begin
      height_cl = CFG_W'(ROW_LIMIT);
    end else begin
      height_cl = height_q;
    end
    height_m1 = height_cl - CFG_W'(1);
  end

  // ---------------------------------------------------------------------
  // Flow control: the whole pipe advances unless a result sits unclaimed.
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic advance;
  logic in_accept;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  // ---------------------------------------------------------------------
  // Stage 0: position tracking, line-buffer read
  // ---------------------------------------------------------------------
  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic             col_end, row_end, emit_cur, last_cur;

  always_comb begin
    col_cur  = in_frame_start_i ? '0 : col_q;
    row_cur  = in_frame_start_i ? '0 : row_q;
    col_end  = EW'(col_cur) >= width_m1;
    row_end  = CFG_W'(row_cur) >= height_m1;
    emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
    last_cur = (CFG_W'(row_cur) == height_m1) && (EW'(col_cur) == width_m1);
    col_d    = col_q;
    row_d    = row_q;
    if (in_accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: current column, buffer write-back, window shift, gradients
  // ---------------------------------------------------------------------
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_idx_q;
  logic             s1_emit_q, s1_last_q;
  logic             s1_hit_q;
  logic [PIX_W-1:0] s1_fwd_top_q, s1_fwd_mid_q;

  logic [PIX_W-1:0] above_rd, two_above_rd;
  col_t             cur_col;
  logic             s1_fire;

  assign s1_fire = s1_valid_q && advance;

  // The item just ahead writes its column at the edge this one reads, so
  // take its data directly when both hit the same column.
  always_comb begin
    cur_col.top = s1_hit_q ? s1_fwd_top_q : two_above_rd;
    cur_col.mid = s1_hit_q ? s1_fwd_mid_q : above_rd;
    cur_col.bot = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q     <= in_pixel_i;
      s1_idx_q     <= col_cur;
      s1_emit_q    <= emit_cur;
      s1_last_q    <= last_cur;
      s1_hit_q     <= s1_valid_q && (s1_idx_q == col_cur);
      s1_fwd_top_q <= cur_col.mid;
      s1_fwd_mid_q <= s1_pix_q;
    end
  end

  sem_line_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_line_above (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_cur),
    .rd_data_o (above_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (s1_pix_q)
  );

  sem_line_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_line_two_above (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_cur),
    .rd_data_o (two_above_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (cur_col.mid)
  );

  // Window: cell 0 holds the centre column, cell 1 the left column.
  col_t       cell_col   [WIN_COLS];
  col_terms_t cell_terms [WIN_COLS];

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    col_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = cur_col;
    end else begin : g_link
      assign cell_in = cell_col[i-1];
    end
    sem_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_fire),
      .col_i   (cell_in),
      .col_o   (cell_col[i]),
      .terms_o (cell_terms[i])
    );
  end

  col_terms_t        right_terms;
  logic signed [10:0] grad_x, grad_y;
  logic [10:0]        abs_x, abs_y, mag_sum;
  logic [PIX_W-1:0]   mag_sat;

  always_comb begin
    right_terms = col_terms(cur_col);
    grad_x = $signed({1'b0, right_terms.wsum}) -
             $signed({1'b0, cell_terms[WIN_COLS-1].wsum});
    grad_y = 11'(cell_terms[WIN_COLS-1].diff) + (11'(cell_terms[0].diff) <<< 1) +
             11'(right_terms.diff);
    abs_x   = grad_x[10] ? 11'(-grad_x) : 11'(grad_x);
    abs_y   = grad_y[10] ? 11'(-grad_y) : 11'(grad_y);
    mag_sum = abs_x + abs_y;
    mag_sat = (mag_sum > 11'(SAT_MAX)) ? PIX_W'(SAT_MAX) : mag_sum[PIX_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] out_mag_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out_mag_q  <= mag_sat;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_magnitude_o = out_mag_q;
  assign out_last_o      = out_last_q;

endmodule

>>> sv/sem_checker.sv
// Port-level checks for sobel_edge_magnitude, bound to the top level.
// Depends on sem_pkg for the field widths.
module sem_assertions (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [sem_pkg::PIX_W-1:0] out_magnitude_o,
  input logic                      out_last_o
);
  import sem_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_magnitude_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // Stall the input only behind an unclaimed result.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // The item after the end of a frame sits on the top border.
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_last_o |=> !out_valid_o)
    else $error("result right after the last one of a frame");

  // Leave reset with an empty output stage.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind sobel_edge_magnitude sem_assertions u_sem_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_magnitude_o (out_magnitude_o),
  .out_last_o      (out_last_o)
);

>>> bench/sem_checker.sv
`timescale 1ns / 1ps
// Result checker for the Sobel edge magnitude block: tracks both channels and
// the register writes, predicts each result and compares it. Depends on sem_pkg.
module sem_checker
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [PIX_W-1:0] in_pixel_i,
  input  logic             in_frame_start_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [PIX_W-1:0] out_magnitude_i,
  input  logic             out_last_i,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             last;
  } sobel_out_t;

  sobel_out_t       due_results[$];
  logic [PIX_W-1:0] row_one_up[MAX_WIDTH];
  logic [PIX_W-1:0] row_two_up[MAX_WIDTH];
  col_t             col_back1;
  col_t             col_back2;
  logic [ROW_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v,
                                             input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the window by one pixel and queue the magnitude it yields, if any.
  task automatic sobel_predict(input logic [PIX_W-1:0] pix, input logic frame_start);
    int unsigned w, h, c, r;
    int          tr, mr, br, gx, gy, mag;
    sobel_out_t  res;
    col_t        fresh;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, ROW_LIMIT);
    if (frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    c  = col_pos;
    r  = row_pos;
    tr = int'(row_two_up[c]);
    mr = int'(row_one_up[c]);
    br = int'(pix);
    if (r >= 2 && c >= 2) begin
      gx = (tr + 2 * mr + br)
         - (int'(col_back2.top) + 2 * int'(col_back2.mid) + int'(col_back2.bot));
      gy = (int'(col_back2.bot) + 2 * int'(col_back1.bot) + br)
         - (int'(col_back2.top) + 2 * int'(col_back1.top) + tr);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > int'(SAT_MAX)) mag = SAT_MAX;
      res.magnitude = PIX_W'(mag);
      res.last      = (r == h - 1) && (c == w - 1);
      due_results.push_back(res);
    end
    row_two_up[c] = PIX_W'(mr);
    row_one_up[c] = pix;
    fresh.top = PIX_W'(tr);
    fresh.mid = PIX_W'(mr);
    fresh.bot = pix;
    col_back2 = col_back1;
    col_back1 = fresh;
    if (c >= w - 1) begin
      col_pos = '0;
      row_pos = (r >= h - 1) ? '0 : ROW_W'(r + 1);
    end else begin
      col_pos = ROW_W'(c + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sobel_out_t want;
    if (!rst_ni) begin
      due_results.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_one_up[i] = '0;
        row_two_up[i] = '0;
      end
      col_back1    = '0;
      col_back2    = '0;
      col_pos      = '0;
      row_pos      = '0;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_wdata_i;
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) sobel_predict(in_pixel_i, in_frame_start_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: magnitude %0d, last %0b", out_magnitude_i, out_last_i);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (out_magnitude_i !== want.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, out_magnitude_i);
            fail_count_o++;
          end
          if (out_last_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = due_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the Sobel edge magnitude block.
// Depends on sem_pkg, sobel_edge_magnitude and sem_checker.
module tb_top;
  import sem_pkg::*;

  // Pause after the last expected result before touching the registers or
  // ending the run: the block holds an item in its pipeline registers,
  // so a pixel that gives no result may still be inside.
  localparam int DRAIN_CYCLES = 8;
  // Cycle limit that ends a hung run; allow plenty.
  localparam int CYCLE_LIMIT  = 400000;
  // Items spent on random small geometries.
  localparam int RANDOM_ITEMS = 1030;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_magnitude;
  logic             out_last;
  logic             cfg_we = 1'b0;
  cfg_addr_e        cfg_addr = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;
  int               cycle_cnt = 0;

  always #6 clk = ~clk;

  sobel_edge_magnitude u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_pixel_i       (in_pixel),
    .in_frame_start_i (in_frame_start),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_magnitude_o  (out_magnitude),
    .out_last_o       (out_last),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata)
  );

  sem_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_pixel_i       (in_pixel),
    .in_frame_start_i (in_frame_start),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_magnitude_i  (out_magnitude),
    .out_last_i       (out_last),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Idle in about a quarter of the cycles, except in the first fifth of every
  // period of the cycle count, where both sides run flat out.
  function automatic bit take_break();
    return ((cycle_cnt % 5000) >= 1000) && ($urandom_range(0, 99) < 24);
  endfunction

  // Count cycles and kill a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result side at random, independent of anything else.
  always @(posedge clk) begin
    out_stall <= take_break();
  end

  // Offer one item and hold it until accepted; valid stays high on return so
  // that back-to-back items need no second assignment in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= frame_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every expected result is out, then let the pipeline drain.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic configure(input logic [CFG_W-1:0] w_cfg, input logic [CFG_W-1:0] h_cfg);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w_cfg;
    @(posedge clk);
    cfg_addr  <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h_cfg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stream raster pixels. The first item restarts the frame so that no line
  // buffer entry left over from another width is ever read; afterwards
  // frames wrap on their own, with a rare restart in mid-frame as noise.
  // Styles: 0 full-range noise, 1 only black and white, 2 low-contrast
  // texture so that magnitudes stay below saturation.
  task automatic run_items(input int n_items, input int style);
    int               lvl;
    logic [PIX_W-1:0] pix;
    lvl = $urandom_range(0, 248);
    for (int i = 0; i < n_items; i++) begin
      case (style)
        0: pix = PIX_W'($urandom_range(0, 255));
        1: pix = $urandom_range(0, 1) ? PIX_W'(255) : PIX_W'(0);
        default: pix = PIX_W'(lvl + $urandom_range(0, 7));
      endcase
      send_pixel(pix, (i == 0) || ($urandom_range(0, 299) == 0));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] w_cfg, h_cfg;
    int               wu, hu, n_items, small_total;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry (640 x 480): a stretch of the top border, no result due.
    run_items(300, 2);

    // Directed frames at the smallest geometry.
    configure(CFG_W'(3), CFG_W'(3));
    // Black left, white right: horizontal gradient saturates; last is set.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_pixel((c == 2) ? PIX_W'(255) : PIX_W'(0), (r == 0) && (c == 0));
      end
    end
    // Start a frame, abandon it after four pixels.
    for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
    // Restart in mid-frame: white top row over black, negative vertical gradient.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_pixel((r == 0) ? PIX_W'(255) : PIX_W'(0), (r == 0) && (c == 0));
      end
    end
    in_valid <= 1'b0;

    // Random small geometries, including values below the minimum that the
    // block clamps up to three.
    small_total = 0;
    while (small_total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: w_cfg = CFG_W'($urandom_range(0, 2));
        1: w_cfg = CFG_W'(3);
        2, 3: w_cfg = CFG_W'($urandom_range(4, 12));
        default: w_cfg = CFG_W'($urandom_range(13, 40));
      endcase
      case ($urandom_range(0, 3))
        0: h_cfg = CFG_W'($urandom_range(0, 2));
        1: h_cfg = CFG_W'(3);
        default: h_cfg = CFG_W'($urandom_range(4, 10));
      endcase
      wu = (w_cfg < 3) ? 3 : int'(w_cfg);
      hu = (h_cfg < 3) ? 3 : int'(h_cfg);
      n_items = $urandom_range(1, 3) * wu * hu + $urandom_range(0, 2 * wu);
      if (n_items > RANDOM_ITEMS - small_total) n_items = RANDOM_ITEMS - small_total;
      configure(w_cfg, h_cfg);
      run_items(n_items, $urandom_range(0, 2));
      small_total += n_items;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
